### hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, command codes and round tables for the MD5 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    // command codes carried on the input tuser
    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_FINISH  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // chaining word start values
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_RND_A,
        ST_RND_B,
        ST_FOLD,
        ST_OUT
    } md5_state_t;

    // byte write into the block buffer
    typedef struct packed {
        logic       en;
        logic [3:0] word;
        logic [1:0] lane;
        logic [7:0] data;
    } md5_wr_t;

    function automatic logic [31:0] round_k(input logic [5:0] rnd);
        logic [31:0] k;
        unique case (rnd)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_rot(input logic [5:0] rnd);
        logic [4:0] s;
        unique case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
            4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;
            4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used in a round, arithmetic is mod 16
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: idx = lo;
            2'd1: idx = lo * 4'd5 + 4'd1;
            2'd2: idx = lo * 4'd3 + 4'd5;
            2'd3: idx = lo * 4'd7;
            default: idx = lo;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

### hdl/md5_stream_hasher.sv
// ----------------------------------------------------------------------------
// md5_stream_hasher
// MD5 message digest over a byte stream with finish and restart commands.
// ----------------------------------------------------------------------------
// Each input beat carries one command in tuser and one byte in tdata. A data
// byte is written into the block buffer as it is taken; the byte that
// completes a 64-byte block makes the block busy while it is loaded, the
// single round unit runs the 64 rounds through ST_RND_A and ST_RND_B, and the
// result folds into the chaining words. Finish writes the 0x80 byte as it is
// taken and the rest of the padding one byte per cycle, then compresses; when
// fewer than nine bytes are left in the block, a further 64 padding bytes and
// a second compression follow. The digest is then held on the output until it
// is taken. Restart, unused codes and beats after a finish are taken without
// leaving the idle state. tready is low while a block is being padded or
// compressed and while the digest waits.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_stream_hasher
    import md5_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // data_byte[7:0]
    input  wire logic [1:0]   s_axis_tuser,   // cmd[1:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [127:0] m_axis_tdata    // digest_low[63:0], digest_high[127:64]
);

    md5_state_t  state_reg, state_next;

    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [63:0] len_reg, len_next;
    logic        done_reg, done_next;
    logic        fin_reg, fin_next;
    logic        len_blk_reg, len_blk_next;
    logic [5:0]  pad_pos_reg, pad_pos_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] sum_reg, sum_next;

    md5_wr_t     wr;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic [31:0] sum1;
    logic [31:0] b_new;

    logic        in_fire;
    logic [5:0]  pos;
    logic [7:0]  len_byte;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign pos      = len_reg[8:3];
    assign len_byte = len_reg[{pad_pos_reg[2:0], 3'b000} +: 8];

    md5_blk_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    md5_round u_round (
        .rnd    (rnd_reg),
        .a      (a_reg),
        .b      (b_reg),
        .c      (c_reg),
        .d      (d_reg),
        .w      (rd_data),
        .sum_in (sum_reg),
        .sum1   (sum1),
        .b_new  (b_new)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !done_reg)
                begin
                    if (s_axis_tuser == CMD_DATA && pos == LAST_POS)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (s_axis_tuser == CMD_FINISH)
                    begin
                        state_next = (pos == LAST_POS) ? ST_LOAD : ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_pos_reg == LAST_POS)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_RND_A;
            ST_RND_A: state_next = ST_RND_B;
            ST_RND_B: state_next = (rnd_reg == LAST_POS) ? ST_FOLD : ST_RND_A;
            ST_FOLD:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = len_blk_reg ? ST_OUT : ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        chain_next   = chain_reg;
        len_next     = len_reg;
        done_next    = done_reg;
        fin_next     = fin_reg;
        len_blk_next = len_blk_reg;
        pad_pos_next = pad_pos_reg;
        rnd_next     = rnd_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        sum_next     = sum_reg;
        wr           = '0;
        rd_addr      = msg_index(rnd_reg);

        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_OUT);
        m_axis_tdata  = {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (s_axis_tuser == CMD_RESTART)
                    begin
                        chain_next[0] = IV_A;
                        chain_next[1] = IV_B;
                        chain_next[2] = IV_C;
                        chain_next[3] = IV_D;
                        len_next      = '0;
                        done_next     = 1'b0;
                        fin_next      = 1'b0;
                    end
                    else if (done_reg)
                    begin
                        // beats after finish are dropped
                    end
                    else if (s_axis_tuser == CMD_DATA)
                    begin
                        wr.en    = 1'b1;
                        wr.word  = pos[5:2];
                        wr.lane  = pos[1:0];
                        wr.data  = s_axis_tdata;
                        len_next = len_reg + 64'd8;
                    end
                    else if (s_axis_tuser == CMD_FINISH)
                    begin
                        wr.en        = 1'b1;
                        wr.word      = pos[5:2];
                        wr.lane      = pos[1:0];
                        wr.data      = PAD_BYTE;
                        fin_next     = 1'b1;
                        len_blk_next = (pos < LEN_POS);
                        pad_pos_next = pos + 6'd1;
                    end
                    else
                    begin
                        // unused code
                    end
                end
            end
            ST_PAD:
            begin
                wr.en   = 1'b1;
                wr.word = pad_pos_reg[5:2];
                wr.lane = pad_pos_reg[1:0];
                wr.data = (len_blk_reg && pad_pos_reg >= LEN_POS) ? len_byte : 8'h00;
                pad_pos_next = pad_pos_reg + 6'd1;
            end
            ST_LOAD:
            begin
                a_next   = chain_reg[0];
                b_next   = chain_reg[1];
                c_next   = chain_reg[2];
                d_next   = chain_reg[3];
                rnd_next = '0;
                rd_addr  = msg_index(6'd0);
            end
            ST_RND_A:
            begin
                sum_next = sum1;
            end
            ST_RND_B:
            begin
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = b_new;
                rnd_next = rnd_reg + 6'd1;
                // fetch the word for the following round
                rd_addr  = msg_index(rnd_reg + 6'd1);
            end
            ST_FOLD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (fin_reg)
                begin
                    if (len_blk_reg)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        len_blk_next = 1'b1;
                        pad_pos_next = '0;
                    end
                end
            end
            ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
            len_reg      <= '0;
            done_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            len_blk_reg  <= 1'b0;
            pad_pos_reg  <= '0;
            rnd_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            len_reg      <= len_next;
            done_reg     <= done_next;
            fin_reg      <= fin_next;
            len_blk_reg  <= len_blk_next;
            pad_pos_reg  <= pad_pos_next;
            rnd_reg      <= rnd_next;
        end
    end

    // working variables, no reset
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        sum_reg <= sum_next;
    end

endmodule

`default_nettype wire

### hdl/md5_blk_ram.sv
// ----------------------------------------------------------------------------
// md5_blk_ram
// 16 x 32 bit block buffer, byte write, registered word read.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_blk_ram
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire md5_wr_t     wr,
    input  wire logic [3:0]  rd_addr,
    output logic      [31:0] rd_data
);

    logic [31:0] mem [16];

    always_ff @(posedge clk)
    begin
        for (int lane = 0; lane < 4; lane++)
        begin
            if (wr.en && wr.lane == lane[1:0])
            begin
                mem[wr.word][8*lane +: 8] <= wr.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// Shared round unit: first half adds a, K and the message word, second half
// applies the round function, rotates and adds b.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_round
    import md5_pkg::*;
(
    input  wire logic [5:0]  rnd,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] c,
    input  wire logic [31:0] d,
    input  wire logic [31:0] w,
    input  wire logic [31:0] sum_in,
    output logic      [31:0] sum1,
    output logic      [31:0] b_new
);

    logic [31:0] f;
    logic [31:0] pre_rot;
    logic [63:0] rot_wide;

    always_comb
    begin
        unique case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = '0;
        endcase
    end

    assign sum1     = a + round_k(rnd) + w;
    assign pre_rot  = sum_in + f;
    // rotate left by shifting a doubled copy
    assign rot_wide = {pre_rot, pre_rot} << round_rot(rnd);
    assign b_new    = b + rot_wide[63:32];

endmodule

`default_nettype wire

### hdl/md5_stream_checker.sv
// ----------------------------------------------------------------------------
// md5_stream_checker
// Port-level checks for the MD5 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_stream_checker
    import md5_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [1:0]   s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata
);

    // never takes input while a digest is pending
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest pending");

    // a stalled digest beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest beat changed while stalled");

    // after the digest is taken the input side opens again
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
        else $error("input not reopened after digest");

    // a digest only appears after a busy stretch
    a_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("digest without compression");

    // a data byte never yields a digest next cycle
    a_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_DATA
        |=> !m_axis_tvalid)
        else $error("digest after data byte");

endmodule

bind md5_stream_hasher md5_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### bench/md5_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// md5_stream_hasher_tb
// Self-checking bench for the MD5 stream hasher.
// ----------------------------------------------------------------------------
// The bench feeds byte messages framed by restart and finish commands, with
// stray commands mixed in. A software MD5 in the scoreboard follows every
// accepted beat and queues the digest that each finish should produce. The
// output side stalls on its own pattern and now and then holds off for a
// long stretch. Each digest is compared half by half, in order, against the
// queue.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_stream_hasher_tb
    import md5_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN_CYCLES = 400;

    // running MD5 over the accepted beats, with the digests still owed
    class md5_scoreboard;
        logic [31:0]  chain [4];
        logic [7:0]   blk [64];
        logic [63:0]  bit_len;
        bit           done;
        logic [31:0]  sine_k [64];
        int           shift_amt [16];
        logic [127:0] digests_due [$];
        int           n_errors;
        int           n_digests;

        function new();
            sine_k = '{
                32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
            };
            shift_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            foreach (blk[i])
            begin
                blk[i] = 8'h00;
            end
            n_errors = 0;
            n_digests = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            bit_len = 64'd0;
            done = 1'b0;
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, f, t, sum;
            int          r, g, s;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++)
            begin
                r = i / 16;
                case (r)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1:
                    begin
                        f = (b & d) | (c & ~d);
                        g = (5 * i + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                s = shift_amt[r * 4 + i % 4];
                sum = a + f + sine_k[i] + w[g];
                t = d;
                d = c;
                c = b;
                b = b + ((sum << s) | (sum >> (32 - s)));
                a = t;
            end
            chain[0] = chain[0] + a;
            chain[1] = chain[1] + b;
            chain[2] = chain[2] + c;
            chain[3] = chain[3] + d;
        endfunction

        // returns 1 when the beat changes the hasher, 0 when it is ignored
        function bit note_beat(logic [1:0] cmd, logic [7:0] dbyte);
            int pos;
            pos = int'(bit_len[8:3]);
            if (cmd == CMD_RESTART)
            begin
                restart();
                return 1'b1;
            end
            if (cmd == CMD_UNUSED || done)
                return 1'b0;
            if (cmd == CMD_DATA)
            begin
                blk[pos] = dbyte;
                bit_len = bit_len + 64'd8;
                if (pos == 63)
                    compress();
                return 1'b1;
            end
            blk[pos] = 8'h80;
            pos++;
            // no room for the length: spill into one more block
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
            begin
                blk[56 + i] = bit_len[8*i +: 8];
            end
            compress();
            done = 1'b1;
            digests_due.push_back({chain[3], chain[2], chain[1], chain[0]});
            n_digests++;
            return 1'b1;
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch %0d: %s expected %h got %h", n_errors, what, want, got);
        endfunction

        function void check_digest(logic [127:0] got);
            logic [127:0] want;
            if (digests_due.size() == 0)
            begin
                flag("unexpected digest", 64'd0, got[63:0]);
                return;
            end
            want = digests_due.pop_front();
            if (got[63:0] !== want[63:0])
                flag("digest_low", want[63:0], got[63:0]);
            if (got[127:64] !== want[127:64])
                flag("digest_high", want[127:64], got[127:64]);
        endfunction

        function int pending();
            return digests_due.size();
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;   // data_byte[7:0]
    logic [1:0]   s_axis_tuser = CMD_DATA; // cmd[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;           // digest_low[63:0], digest_high[127:64]

    md5_scoreboard sb;
    int            n_used = 0;
    int            burst_left = 0;
    int            hold_req = 0;
    int            hold_seen = 0;
    int            hold_left = 0;
    int            rx_tick = 0;

    md5_stream_hasher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // digest side: check on each beat, then pick the next tready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            rx_tick <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_digest(m_axis_tdata);
            rx_tick <= rx_tick + 1;
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case ((rx_tick / 256) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_axis_tready <= (rx_tick % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic drive_beat(input logic [1:0] cmd, input logic [7:0] dbyte);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0:       gap = $urandom_range(10, 30);
                1, 2, 3: gap = 0;
                default: gap = $urandom_range(1, 6);
            endcase
            // occasionally a long run with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= dbyte;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_used += sb.note_beat(cmd, dbyte);
    endtask

    task automatic drain_digests();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (sb.pending() != 0 && guard < 100000);
    endtask

    task automatic stray_beat();
        case ($urandom_range(0, 2))
            0:       drive_beat(CMD_DATA, 8'($urandom_range(0, 255)));
            1:       drive_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
            default: drive_beat(CMD_UNUSED, 8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_message(input int len, input bit noisy);
        drive_beat(CMD_RESTART, 8'($urandom_range(0, 255)));
        for (int k = 0; k < len; k++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                drive_beat(CMD_UNUSED, 8'($urandom_range(0, 255)));
            drive_beat(CMD_DATA, 8'($urandom_range(0, 255)));
        end
        drive_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
        // data and finish after the digest should be dropped
        if (noisy)
            repeat ($urandom_range(1, 3)) stray_beat();
    endtask

    function automatic int message_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(0, 16);
        else if (r < 60)
            return $urandom_range(52, 68);
        else if (r < 80)
            return $urandom_range(0, 64);
        else if (r < 95)
            return $urandom_range(110, 140);
        return $urandom_range(180, 300);
    endfunction

    initial
    begin
        int iter;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty message, then finish, data and the unused code after finish
        drive_beat(CMD_RESTART, 8'h00);
        drive_beat(CMD_FINISH, 8'hff);
        drive_beat(CMD_FINISH, 8'h00);
        drive_beat(CMD_DATA, 8'hff);
        drive_beat(CMD_UNUSED, 8'hff);
        // digest side holds off so the next digest blocks the beats behind it
        hold_req <= hold_req + 1;
        // "abc" with the unused code in the middle
        drive_beat(CMD_RESTART, 8'hff);
        drive_beat(CMD_DATA, 8'h61);
        drive_beat(CMD_DATA, 8'h62);
        drive_beat(CMD_UNUSED, 8'h00);
        drive_beat(CMD_DATA, 8'h63);
        drive_beat(CMD_FINISH, 8'h00);
        // restart part way through a message
        drive_beat(CMD_RESTART, 8'h00);
        drive_beat(CMD_DATA, 8'h00);
        drive_beat(CMD_DATA, 8'hff);
        drive_beat(CMD_RESTART, 8'haa);
        drive_beat(CMD_DATA, 8'h5a);
        drive_beat(CMD_DATA, 8'ha5);
        drive_beat(CMD_FINISH, 8'h55);
        drain_digests();

        iter = 0;
        while (n_used < 1500)
        begin
            iter++;
            // digest side holds off while whole messages keep coming
            if (iter == 8 || $urandom_range(0, 39) == 0)
                hold_req <= hold_req + 1;
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    drive_beat(CMD_RESTART, 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(1, 80))
                        drive_beat(CMD_DATA, 8'($urandom_range(0, 255)));
                end
                2:
                begin
                    repeat ($urandom_range(1, 6))
                        drive_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
                default:
                    send_message(message_len(), $urandom_range(0, 4) == 0);
            endcase
            if (iter == 16 || $urandom_range(0, 29) == 0)
                drain_digests();
        end

        drain_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("md5_stream_hasher test passed");
        else
            $display("md5_stream_hasher test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("md5_stream_hasher test failed");
        $finish;
    end

endmodule

`default_nettype wire

### md5_stream_hasher.f
hdl/md5_pkg.sv
hdl/md5_blk_ram.sv
hdl/md5_round.sv
hdl/md5_stream_hasher.sv
hdl/md5_stream_checker.sv
bench/md5_stream_hasher_tb.sv
